[design/hdlc_nrzi_stuffing_transmitter_macros.svh]
// Assertion macros used by the transmitter datapath.
// They assume the enclosing module has signals named clock and reset.
`ifndef HDLC_NRZI_STUFFING_TRANSMITTER_MACROS_SVH
`define HDLC_NRZI_STUFFING_TRANSMITTER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HNST_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("hnst assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define HNST_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("hnst assertion failed");

`endif

[design/hnst_pkg.sv]
`default_nettype none

package hnst_pkg;

   localparam logic [15:0] CRC_POLY  = 16'h8408;
   localparam logic [15:0] CRC_INIT  = 16'hFFFF;
   localparam logic [2:0]  STUFF_RUN = 3'd5;
   localparam logic [2:0]  RUN_MAX   = 3'd7;
   localparam logic [2:0]  LAST_BIT  = 3'd7;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       is_flag;
      logic       restart_crc;
   } req_type;

   typedef struct packed {
      logic        line_tone;
      logic        stuffed;
      logic        last_symbol;
      logic [15:0] crc_value;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic emit_data;
      logic emit_stuff;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;
      logic will_stuff;
      logic last_bit;
      logic stuff_last;
   } status_type;

endpackage

`default_nettype wire

[design/hnst_controller.sv]
`default_nettype none

module hnst_controller (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  hnst_pkg::status_type status,
   output hnst_pkg::cmd_type   cmd
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_DATA  = 3'b010,
      ST_STUFF = 3'b100
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in       = state_ff;
      cmd.load       = 1'b0;
      cmd.emit_data  = 1'b0;
      cmd.emit_stuff = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DATA;
            end
         end
         ST_DATA: begin
            if (status.out_free) begin
               cmd.emit_data = 1'b1;
               if (status.will_stuff) begin
                  state_in = ST_STUFF;
               end else if (status.last_bit) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_STUFF: begin
            if (status.out_free) begin
               cmd.emit_stuff = 1'b1;
               state_in = status.stuff_last ? ST_IDLE : ST_DATA;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[design/hnst_datapath.sv]
`default_nettype none

`include "hdlc_nrzi_stuffing_transmitter_macros.svh"

module hnst_datapath (
   input  wire                  clock,
   input  wire                  reset,
   input  hnst_pkg::req_type    req_payload,
   input  hnst_pkg::cmd_type    cmd,
   output hnst_pkg::status_type status,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output hnst_pkg::rsp_type    rsp_payload
);

   logic [7:0]        byte_ff, byte_in;
   logic              flag_ff, flag_in;
   logic [2:0]        idx_ff, idx_in;
   logic [15:0]       crc_ff, crc_in;
   logic              level_ff, level_in;
   logic [2:0]        ones_ff, ones_in;
   logic              rsp_valid_ff, rsp_valid_in;
   hnst_pkg::rsp_type rsp_ff, rsp_in;

   logic        cur_bit;
   logic [2:0]  ones_inc;
   logic [15:0] crc_step;
   logic        data_last;

   assign cur_bit  = byte_ff[0];
   assign ones_inc = (ones_ff == hnst_pkg::RUN_MAX) ? ones_ff : ones_ff + 3'd1;
   assign crc_step = {1'b0, crc_ff[15:1]} ^
                     ((crc_ff[0] != cur_bit) ? hnst_pkg::CRC_POLY : 16'h0000);

   assign status.out_free   = !rsp_valid_ff || !rsp_stall;
   assign status.will_stuff = cur_bit && (ones_inc == hnst_pkg::STUFF_RUN) && !flag_ff;
   assign status.last_bit   = (idx_ff == hnst_pkg::LAST_BIT);
   // The bit index has wrapped to zero only when the stuffing follows the final bit.
   assign status.stuff_last = (idx_ff == 3'd0);

   assign data_last = status.last_bit && !status.will_stuff;

   always_comb begin
      byte_in      = byte_ff;
      flag_in      = flag_ff;
      idx_in       = idx_ff;
      crc_in       = crc_ff;
      level_in     = level_ff;
      ones_in      = ones_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (cmd.load) begin
         byte_in = req_payload.data_byte;
         flag_in = req_payload.is_flag;
         idx_in  = 3'd0;
         if (req_payload.restart_crc) begin
            crc_in = hnst_pkg::CRC_INIT;
         end
      end

      if (cmd.emit_data) begin
         byte_in  = {1'b0, byte_ff[7:1]};
         idx_in   = idx_ff + 3'd1;
         crc_in   = crc_step;
         level_in = cur_bit ? level_ff : ~level_ff;
         ones_in  = cur_bit ? ones_inc : 3'd0;
         rsp_valid_in       = 1'b1;
         rsp_in.line_tone   = level_in;
         rsp_in.stuffed     = 1'b0;
         rsp_in.last_symbol = data_last;
         rsp_in.crc_value   = data_last ? crc_step : 16'h0000;
      end

      if (cmd.emit_stuff) begin
         level_in = ~level_ff;
         ones_in  = 3'd0;
         rsp_valid_in       = 1'b1;
         rsp_in.line_tone   = ~level_ff;
         rsp_in.stuffed     = 1'b1;
         rsp_in.last_symbol = status.stuff_last;
         rsp_in.crc_value   = status.stuff_last ? crc_ff : 16'h0000;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 3'd0;
         crc_ff       <= hnst_pkg::CRC_INIT;
         level_ff     <= 1'b1;
         ones_ff      <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         crc_ff       <= crc_in;
         level_ff     <= level_in;
         ones_ff      <= ones_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      flag_ff <= flag_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `HNST_ASSERT_SAME(a_stuff_after_five, cmd.emit_stuff, ones_ff == hnst_pkg::STUFF_RUN)
   `HNST_ASSERT_SAME(a_load_at_byte_start, cmd.load, idx_ff == 3'd0)
   `HNST_ASSERT_SAME(a_crc_only_on_last,
                     rsp_valid_ff && !rsp_ff.last_symbol, rsp_ff.crc_value == 16'h0000)
   `HNST_ASSERT_NEXT(a_stuff_toggles, cmd.emit_stuff, rsp_ff.line_tone == !$past(level_ff))

endmodule

`default_nettype wire

[design/hdlc_nrzi_stuffing_transmitter.sv]
//  Channel  Direction  Handshake            Payload
//  req      in         req_valid/req_stall  hnst_pkg::req_type (byte, flag, crc restart)
//  rsp      out        rsp_valid/rsp_stall  hnst_pkg::rsp_type (one line symbol)
//
//  A byte is taken while idle, then one symbol is produced per cycle while the
//  output register is free, stepped by the bit-index loop.
//  Reset is synchronous: CRC 0xFFFF, line level mark, ones run cleared, output empty.
//  A stall on rsp holds the current symbol and pauses the bit loop; req is stalled
//  until the last symbol of the byte has been produced.
`default_nettype none

module hdlc_nrzi_stuffing_transmitter (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  hnst_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output hnst_pkg::rsp_type rsp_payload
);

   hnst_pkg::cmd_type    cmd;
   hnst_pkg::status_type status;

   hnst_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   hnst_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

[dv/tb_top.sv]
`timescale 1ns / 100ps

// Expected line symbols for the transmitter, built one byte at a time.
class symbol_scoreboard;
   hnst_pkg::rsp_type expected_symbols[$];
   logic [15:0]       crc_reg;
   logic              level_reg;
   logic [2:0]        ones_reg;
   int                error_count;
   int                checked_count;

   function new();
      crc_reg       = hnst_pkg::CRC_INIT;
      level_reg     = 1'b1;
      ones_reg      = 3'd0;
      error_count   = 0;
      checked_count = 0;
   endfunction

   function int pending();
      return expected_symbols.size();
   endfunction

   function void push_symbol(ref hnst_pkg::rsp_type syms[$], input logic is_stuff);
      hnst_pkg::rsp_type s;
      s.line_tone   = level_reg;
      s.stuffed     = is_stuff;
      s.last_symbol = 1'b0;
      s.crc_value   = 16'h0000;
      syms.push_back(s);
   endfunction

   // Called on every accepted byte transfer.
   function void note_byte(hnst_pkg::req_type r);
      hnst_pkg::rsp_type syms[$];
      logic              data_bit;
      logic              feedback;
      if (r.restart_crc) begin
         crc_reg = hnst_pkg::CRC_INIT;
      end
      for (int i = 0; i < 8; i++) begin
         data_bit = r.data_byte[i];
         feedback = crc_reg[0] ^ data_bit;
         crc_reg  = crc_reg >> 1;
         if (feedback) begin
            crc_reg = crc_reg ^ hnst_pkg::CRC_POLY;
         end
         if (data_bit) begin
            push_symbol(syms, 1'b0);
            if (ones_reg < hnst_pkg::RUN_MAX) begin
               ones_reg = ones_reg + 3'd1;
            end
            // Stuffing fires only when the run lands exactly on five.
            if (ones_reg == hnst_pkg::STUFF_RUN && !r.is_flag) begin
               level_reg = ~level_reg;
               push_symbol(syms, 1'b1);
               ones_reg = 3'd0;
            end
         end else begin
            level_reg = ~level_reg;
            push_symbol(syms, 1'b0);
            ones_reg = 3'd0;
         end
      end
      syms[syms.size() - 1].last_symbol = 1'b1;
      syms[syms.size() - 1].crc_value   = crc_reg;
      foreach (syms[i]) begin
         expected_symbols.push_back(syms[i]);
      end
   endfunction

   task report_mismatch(string msg);
      $display("[%0t] MISMATCH symbol %0d: %s", $realtime, checked_count, msg);
      error_count++;
   endtask

   // Called on every accepted symbol transfer.
   task check_symbol(hnst_pkg::rsp_type got);
      hnst_pkg::rsp_type want;
      if (expected_symbols.size() == 0) begin
         report_mismatch($sformatf("unexpected symbol %p", got));
      end else begin
         want = expected_symbols.pop_front();
         if (got.line_tone !== want.line_tone) begin
            report_mismatch($sformatf("line_tone %b, expected %b",
                                      got.line_tone, want.line_tone));
         end
         if (got.stuffed !== want.stuffed) begin
            report_mismatch($sformatf("stuffed %b, expected %b",
                                      got.stuffed, want.stuffed));
         end
         if (got.last_symbol !== want.last_symbol) begin
            report_mismatch($sformatf("last_symbol %b, expected %b",
                                      got.last_symbol, want.last_symbol));
         end
         if (got.crc_value !== want.crc_value) begin
            report_mismatch($sformatf("crc_value %h, expected %h",
                                      got.crc_value, want.crc_value));
         end
      end
      checked_count++;
   endtask
endclass

module tb_top;

   localparam int RANDOM_ITEMS = 330;
   localparam int HOLD_CYCLES  = 300;
   localparam int SETTLE_CYCLES = 30;

   localparam int IDLE_NONE   = 0;
   localparam int IDLE_FULL   = 1;
   localparam int IDLE_SPARSE = 2;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   hnst_pkg::req_type req_payload;
   logic              rsp_valid;
   logic              rsp_stall;
   hnst_pkg::rsp_type rsp_payload;

   symbol_scoreboard book;
   int               send_mode;
   int               rsp_mode;
   bit               hold_rsp;
   int               sent_count;

   hdlc_nrzi_stuffing_transmitter dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic int draw_wait(int mode);
      if (mode == IDLE_NONE) begin
         return 0;
      end else if (mode == IDLE_SPARSE) begin
         return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
      end
      return $urandom_range(0, 16);
   endfunction

   function automatic hnst_pkg::req_type make_req(logic [7:0] data, logic flag,
                                                  logic restart);
      hnst_pkg::req_type r;
      r.data_byte   = data;
      r.is_flag     = flag;
      r.restart_crc = restart;
      return r;
   endfunction

   // Frame content leans toward long runs of ones so stuffing happens often.
   function automatic logic [7:0] pick_payload();
      case ($urandom_range(0, 4))
         0: begin
            return 8'hFF;
         end
         1: begin
            return 8'($urandom | $urandom);
         end
         2: begin
            return 8'($urandom | $urandom | $urandom);
         end
         default: begin
            return 8'($urandom_range(0, 255));
         end
      endcase
   endfunction

   // Both transfers are seen in one place, so a byte is always noted before its symbols.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            book.note_byte(req_payload);
         end
         if (rsp_valid && !rsp_stall) begin
            book.check_symbol(rsp_payload);
         end
      end
   end

   task automatic send_byte(hnst_pkg::req_type r);
      int gap;
      gap = draw_wait(send_mode);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      sent_count++;
   endtask

   task automatic send_frame_traffic(int count);
      int start;
      int len;
      start = sent_count;
      while (sent_count - start < count) begin
         if ($urandom_range(0, 9) < 8) begin
            send_byte(make_req(8'h7E, 1'b1, ($urandom_range(0, 7) != 0)));
            len = $urandom_range(1, 12);
            repeat (len) begin
               send_byte(make_req(pick_payload(), 1'b0, ($urandom_range(0, 15) == 0)));
            end
            send_byte(make_req(8'h7E, 1'b1, 1'b0));
         end else begin
            send_byte(make_req(8'($urandom), 1'($urandom), 1'($urandom)));
         end
      end
   endtask

   // The sender goes idle first, so the last byte is not offered a second time.
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (book.pending() != 0) begin
         @(negedge clock);
      end
   endtask

   // Receiver: a random stall before each symbol, or one long hold when asked.
   initial begin
      int k;
      rsp_stall = 1'b0;
      @(negedge clock);
      while (reset) begin
         @(negedge clock);
      end
      forever begin
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
         end
         k = draw_wait(rsp_mode);
         if (k > 0) begin
            rsp_stall <= 1'b1;
            repeat (k) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do begin
            @(posedge clock);
         end while (!rsp_valid);
         @(negedge clock);
      end
   end

   initial begin
      hnst_pkg::req_type directed[$];
      book        = new();
      send_mode   = IDLE_NONE;
      rsp_mode    = IDLE_NONE;
      hold_rsp    = 1'b0;
      sent_count  = 0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      directed.push_back(make_req(8'h00, 1'b0, 1'b1));
      directed.push_back(make_req(8'hFF, 1'b0, 1'b0));
      directed.push_back(make_req(8'h7E, 1'b1, 1'b0));
      // A flag of all ones saturates the run; the next data ones must not stuff.
      directed.push_back(make_req(8'hFF, 1'b1, 1'b0));
      directed.push_back(make_req(8'hFF, 1'b0, 1'b0));
      directed.push_back(make_req(8'h00, 1'b0, 1'b0));
      // Two ones carried in give two stuffed zeros and the longest byte.
      directed.push_back(make_req(8'hC0, 1'b0, 1'b0));
      directed.push_back(make_req(8'hFF, 1'b0, 1'b0));
      directed.push_back(make_req(8'hF8, 1'b0, 1'b1));
      directed.push_back(make_req(8'hF8, 1'b1, 1'b0));
      directed.push_back(make_req(8'h01, 1'b0, 1'b0));
      directed.push_back(make_req(8'hE0, 1'b1, 1'b0));
      directed.push_back(make_req(8'h03, 1'b0, 1'b0));
      directed.push_back(make_req(8'h1F, 1'b1, 1'b0));
      directed.push_back(make_req(8'h80, 1'b0, 1'b0));
      directed.push_back(make_req(8'h01, 1'b0, 1'b1));
      directed.push_back(make_req(8'h55, 1'b0, 1'b0));
      directed.push_back(make_req(8'hAA, 1'b1, 1'b1));
      directed.push_back(make_req(8'h7F, 1'b0, 1'b0));
      directed.push_back(make_req(8'hFE, 1'b0, 1'b0));
      directed.push_back(make_req(8'h7E, 1'b1, 1'b1));
      foreach (directed[i]) begin
         send_byte(directed[i]);
      end

      send_mode = IDLE_FULL;
      rsp_mode  = IDLE_FULL;
      send_frame_traffic(100);

      send_mode = IDLE_SPARSE;
      rsp_mode  = IDLE_SPARSE;
      send_frame_traffic(80);

      // Long receiver hold while bytes keep coming, so the input backs up.
      send_mode = IDLE_NONE;
      rsp_mode  = IDLE_NONE;
      hold_rsp  = 1'b1;
      send_frame_traffic(40);

      wait_drained();
      send_mode = IDLE_FULL;
      rsp_mode  = IDLE_SPARSE;
      send_frame_traffic(RANDOM_ITEMS - 220);

      @(negedge clock);
      req_valid <= 1'b0;
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (book.error_count == 0 && book.pending() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("Timeout with %0d symbols still expected", book.pending());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

[sim.f]
+incdir+design
design/hnst_pkg.sv
design/hnst_controller.sv
design/hnst_datapath.sv
design/hdlc_nrzi_stuffing_transmitter.sv
dv/tb_top.sv
